[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the path goal arrival checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check an implication on every clock edge outside reset.
`define AST_IMPLY(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Check that a condition never holds outside reset.
`define AST_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("assertion failed");
`else
`define AST_IMPLY(label, lhs, rhs)
`define AST_NEVER(label, expr)
`endif
`endif

[hdl/pgac_pkg.sv]
// Types, codes and defaults shared by the path goal arrival checker.
package pgac_pkg;

   localparam int PATH_DEPTH_DEF = 1024;

   localparam logic [1:0] CSR_XY_TOL     = 2'd0;
   localparam logic [1:0] CSR_TRANS_STOP = 2'd1;
   localparam logic [1:0] CSR_ROT_STOP   = 2'd2;
   localparam logic [1:0] CSR_STABLE     = 2'd3;

   localparam logic [15:0] XY_TOL_RST     = 16'd10;
   localparam logic [15:0] TRANS_STOP_RST = 16'd10;
   localparam logic [15:0] ROT_STOP_RST   = 16'd50;
   localparam logic [7:0]  STABLE_RST     = 8'd5;
   localparam logic [7:0]  STOP_CNT_MAX   = 8'd255;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic               first_point;
      logic               last_point;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] vel_yaw;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       path_ready;
      logic       terminal_reached;
      logic       goal_reached;
   } rsp_type;

endpackage

[hdl/path_goal_arrival_checker_core.sv]
// Path goal arrival checker: path point store, terminal tangent and arrival test.
//
// Usage: req_ beats carry either a path point load (cmd 0) or a pose and
// velocity query (cmd 1); every beat produces exactly one rsp_ beat with
// status, path_ready, terminal_reached and goal_reached. Points are held in
// one synchronous memory of PathDepth entries, x and y side by side.
// csr_ writes set the tolerance, stop speeds and stable count; they are
// taken at any time but must only be issued while the block is idle.
// Order of work: a plain load, a rejected last point or a query without a
// valid path goes straight to the output register. A last point load walks
// back through the memory, reading and checking each point equal to the goal
// in turn. A query with a valid path first forms its goal distance, its
// projection and its speeds, then scans every stored point through a 4-stage
// read/difference/square/compare pipeline at one point per cycle.
// One beat is in work at a time; req_stall is high until its response has
// been moved to the output register. The output register holds the beat
// while rsp_stall is high, and the next beat's work may run meanwhile.
// Reset (synchronous, active high) empties the path, clears all flags and
// loads the register defaults; the memory is not cleared and needs no pass.
`include "assert_macros.svh"

module path_goal_arrival_checker_core
   import pgac_pkg::*;
#(
   parameter int PathDepth = PATH_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int AW = (PathDepth > 1) ? $clog2(PathDepth) : 1;
   localparam int CW = $clog2(PathDepth + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_W_RD, ST_W_CHK, ST_Q_MAG, ST_Q_MUL, ST_Q_CMP, ST_SCAN, ST_FIN, ST_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [15:0] tol_ff, tss_ff, rss_ff;
   logic [7:0]  stab_ff;

   // path state
   logic [CW-1:0]      count_ff;
   logic               ovf_ff, path_ok_ff, latch_ff;
   logic [7:0]         stop_ff;
   logic [AW-1:0]      tsi_ff, walk_ff;
   logic signed [32:0] tdx_ff, tdy_ff;
   logic [31:0]        goal_x_ff, goal_y_ff;

   // query operands and products
   logic [31:0]        qx_ff, qy_ff;
   logic [15:0]        vmx_ff, vmy_ff, vmw_ff;
   logic signed [32:0] gdx_ff, gdy_ff;
   logic [31:0]        gmx_ff, gmy_ff;
   logic [63:0]        gsx_ff, gsy_ff;
   logic signed [65:0] pjx_ff, pjy_ff;
   logic [31:0]        v2x_ff, v2y_ff, tol2_ff, tss2_ff;
   logic               near_ff, proj_ff, still_ff;

   // scan pipeline
   logic [CW-1:0] iss_ff;
   logic          s1_v_ff, s2_v_ff, s3_v_ff, best_v_ff;
   logic [AW-1:0] s1_i_ff, s2_i_ff, s3_i_ff, best_i_ff;
   logic [31:0]   s2_mx_ff, s2_my_ff;
   logic [63:0]   s3_sx_ff, s3_sy_ff;
   logic [64:0]   best_ff;

   // memory and output
   logic [63:0]   mem [PathDepth];
   logic [63:0]   rd_data_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff, res_ff;

   logic          req_acc;
   logic [CW-1:0] cnt_base, cnt_new;
   logic          room, ovf_new, wr_en;
   logic [1:0]    load_status;
   logic          load_walk;
   logic [AW-1:0] rd_addr;
   logic signed [32:0] qdx, qdy, sdx, sdy;
   logic [64:0]   e_sum, near_sum;
   logic signed [66:0] proj_sum;
   logic [32:0]   v2_sum;
   logic          arrived;
   logic [7:0]    stop_n;

   assign req_stall = state_ff != ST_IDLE;
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // store slot for a load beat
   always_comb begin
      cnt_base = req_data.first_point ? '0 : count_ff;
      room     = cnt_base < CW'(PathDepth);
      cnt_new  = room ? cnt_base + CW'(1) : cnt_base;
      ovf_new  = (req_data.first_point ? 1'b0 : ovf_ff) | !room;
      wr_en    = req_acc && (req_data.cmd == CMD_LOAD) && room;
      rd_addr  = (state_ff == ST_SCAN) ? iss_ff[AW-1:0] : walk_ff;
      // walk back only for a last point of a path that can hold a tangent
      load_walk = req_data.last_point && !ovf_new && (cnt_new >= CW'(2));
      if (!room || (req_data.last_point && ovf_new)) begin
         load_status = STATUS_OVERFLOW;
      end else if (req_data.last_point && (cnt_new < CW'(2))) begin
         load_status = STATUS_INVALID;
      end else begin
         load_status = STATUS_OK;
      end
   end

   // point memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[cnt_base[AW-1:0]] <= {req_data.pos_x, req_data.pos_y};
      end
      rd_data_ff <= mem[rd_addr];
   end

   // arithmetic between stages
   always_comb begin
      qdx      = {qx_ff[31], qx_ff} - {goal_x_ff[31], goal_x_ff};
      qdy      = {qy_ff[31], qy_ff} - {goal_y_ff[31], goal_y_ff};
      sdx      = {qx_ff[31], qx_ff} - {rd_data_ff[63], rd_data_ff[63:32]};
      sdy      = {qy_ff[31], qy_ff} - {rd_data_ff[31], rd_data_ff[31:0]};
      e_sum    = {1'b0, s3_sx_ff} + {1'b0, s3_sy_ff};
      near_sum = {1'b0, gsx_ff} + {1'b0, gsy_ff};
      proj_sum = {pjx_ff[65], pjx_ff} + {pjy_ff[65], pjy_ff};
      v2_sum   = {1'b0, v2x_ff} + {1'b0, v2y_ff};
      arrived  = latch_ff || near_ff || ((best_i_ff >= tsi_ff) && proj_ff);
      if (!arrived || !still_ff) begin
         stop_n = '0;
      end else if (stop_ff == STOP_CNT_MAX) begin
         stop_n = stop_ff;
      end else begin
         stop_n = stop_ff + 8'd1;
      end
   end

   // sequencer and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tol_ff       <= XY_TOL_RST;
         tss_ff       <= TRANS_STOP_RST;
         rss_ff       <= ROT_STOP_RST;
         stab_ff      <= STABLE_RST;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         path_ok_ff   <= 1'b0;
         latch_ff     <= 1'b0;
         stop_ff      <= '0;
         tsi_ff       <= '0;
         tdx_ff       <= '0;
         tdy_ff       <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         best_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // configuration writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_XY_TOL:     tol_ff  <= csr_wdata;
               CSR_TRANS_STOP: tss_ff  <= csr_wdata;
               CSR_ROT_STOP:   rss_ff  <= csr_wdata;
               CSR_STABLE:     stab_ff <= csr_wdata[7:0];
               default:        tol_ff  <= tol_ff;
            endcase
         end

         // raise the output beat when a result moves in, drop it once taken
         if ((state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // scan pipeline advances every cycle
         s2_v_ff  <= s1_v_ff;
         s2_i_ff  <= s1_i_ff;
         s2_mx_ff <= sdx[32] ? 32'(-sdx) : sdx[31:0];
         s2_my_ff <= sdy[32] ? 32'(-sdy) : sdy[31:0];
         s3_v_ff  <= s2_v_ff;
         s3_i_ff  <= s2_i_ff;
         s3_sx_ff <= s2_mx_ff * s2_mx_ff;
         s3_sy_ff <= s2_my_ff * s2_my_ff;
         if (s3_v_ff && (!best_v_ff || (e_sum < best_ff))) begin
            best_ff   <= e_sum;
            best_i_ff <= s3_i_ff;
            best_v_ff <= 1'b1;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  if (req_data.cmd == CMD_LOAD) begin
                     count_ff   <= cnt_new;
                     ovf_ff     <= ovf_new;
                     path_ok_ff <= 1'b0;
                     latch_ff   <= 1'b0;
                     stop_ff    <= '0;
                     res_ff     <= '{load_status, 1'b0, 1'b0, 1'b0};
                     if (load_walk) begin
                        goal_x_ff <= req_data.pos_x;
                        goal_y_ff <= req_data.pos_y;
                        walk_ff   <= AW'(cnt_new - CW'(2));
                        state_ff  <= ST_W_RD;
                     end else begin
                        state_ff  <= ST_OUT;
                     end
                  end else if (!path_ok_ff) begin
                     stop_ff  <= '0;
                     res_ff   <= '{STATUS_INVALID, 1'b0, 1'b0, 1'b0};
                     state_ff <= ST_OUT;
                  end else begin
                     qx_ff    <= req_data.pos_x;
                     qy_ff    <= req_data.pos_y;
                     vmx_ff   <= req_data.vel_x[15] ? 16'(-req_data.vel_x) : req_data.vel_x;
                     vmy_ff   <= req_data.vel_y[15] ? 16'(-req_data.vel_y) : req_data.vel_y;
                     vmw_ff   <= req_data.vel_yaw[15] ? 16'(-req_data.vel_yaw)
                                                      : req_data.vel_yaw;
                     state_ff <= ST_Q_MAG;
                  end
               end
            end
            ST_W_RD: begin
               state_ff <= ST_W_CHK;
            end
            ST_W_CHK: begin
               // walk back to the first point that differs from the goal
               if (rd_data_ff != {goal_x_ff, goal_y_ff}) begin
                  tsi_ff        <= walk_ff;
                  tdx_ff        <= {goal_x_ff[31], goal_x_ff}
                                   - {rd_data_ff[63], rd_data_ff[63:32]};
                  tdy_ff        <= {goal_y_ff[31], goal_y_ff}
                                   - {rd_data_ff[31], rd_data_ff[31:0]};
                  path_ok_ff    <= 1'b1;
                  res_ff.status <= STATUS_OK;
                  res_ff.path_ready <= 1'b1;
                  state_ff      <= ST_OUT;
               end else if (walk_ff == '0) begin
                  res_ff.status <= STATUS_INVALID;
                  state_ff      <= ST_OUT;
               end else begin
                  walk_ff  <= walk_ff - AW'(1);
                  state_ff <= ST_W_RD;
               end
            end
            ST_Q_MAG: begin
               gdx_ff   <= qdx;
               gdy_ff   <= qdy;
               gmx_ff   <= qdx[32] ? 32'(-qdx) : qdx[31:0];
               gmy_ff   <= qdy[32] ? 32'(-qdy) : qdy[31:0];
               state_ff <= ST_Q_MUL;
            end
            ST_Q_MUL: begin
               gsx_ff    <= gmx_ff * gmx_ff;
               gsy_ff    <= gmy_ff * gmy_ff;
               pjx_ff    <= gdx_ff * tdx_ff;
               pjy_ff    <= gdy_ff * tdy_ff;
               v2x_ff    <= vmx_ff * vmx_ff;
               v2y_ff    <= vmy_ff * vmy_ff;
               tol2_ff   <= tol_ff * tol_ff;
               tss2_ff   <= tss_ff * tss_ff;
               iss_ff    <= '0;
               best_v_ff <= 1'b0;
               state_ff  <= ST_Q_CMP;
            end
            ST_Q_CMP: begin
               near_ff  <= near_sum <= {33'd0, tol2_ff};
               proj_ff  <= !proj_sum[66];
               still_ff <= (v2_sum <= {1'b0, tss2_ff}) && (vmw_ff <= rss_ff);
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               // issue one point a cycle, finish when the pipeline drains
               if (iss_ff < count_ff) begin
                  s1_v_ff <= 1'b1;
                  s1_i_ff <= iss_ff[AW-1:0];
                  iss_ff  <= iss_ff + CW'(1);
               end else begin
                  s1_v_ff <= 1'b0;
                  if (!s1_v_ff && !s2_v_ff && !s3_v_ff) begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            ST_FIN: begin
               latch_ff <= arrived;
               stop_ff  <= stop_n;
               res_ff.status           <= STATUS_OK;
               res_ff.path_ready       <= 1'b1;
               res_ff.terminal_reached <= arrived;
               res_ff.goal_reached     <= arrived && (stop_n >= stab_ff);
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               // hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff  <= res_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `AST_IMPLY(a_path_len, path_ok_ff, count_ff >= CW'(2))
   `AST_IMPLY(a_tangent_nz, path_ok_ff, (tdx_ff != '0) || (tdy_ff != '0))
   `AST_IMPLY(a_stop_latched, stop_ff != '0, latch_ff)
   `AST_NEVER(a_goal_term, rsp_valid_ff && rsp_data_ff.goal_reached && !rsp_data_ff.terminal_reached)

endmodule
